// ===== rtl/b2da_pkg.sv =====
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int STEPS_PER_STAGE = 8;
   localparam int DIGIT_W         = 4;
   localparam int CHAR_W          = 6;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
   localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

endpackage

// ===== rtl/b2da_if.sv =====
// ----------------------------------------------------------------------------
// b2da_if
// Valid/ready channels for the number input and the character output.
// ----------------------------------------------------------------------------
interface b2da_req_if #(
   parameter int VALUE_BITS = 32
);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface b2da_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [b2da_pkg::CHAR_W-1:0]   char_code;
   logic                          last_digit;

   modport source (output valid, output char_code, output last_digit, input ready);
   modport sink   (input valid, input char_code, input last_digit, output ready);
endinterface

// ===== rtl/b2da_dabble_stage.sv =====
// ----------------------------------------------------------------------------
// b2da_dabble_stage
// One pipeline stage of the shift and add-3 conversion, a fixed number of
// bit steps per stage, with its own valid bit and stall handling.
// ----------------------------------------------------------------------------
module b2da_dabble_stage #(
   parameter int PAD_W = 32,
   parameter int BCD_W = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [PAD_W-1:0] in_bin,
   input  logic [BCD_W-1:0] in_bcd,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [PAD_W-1:0] out_bin,
   output logic [BCD_W-1:0] out_bcd
);

   localparam int NUM_DIGITS = BCD_W / b2da_pkg::DIGIT_W;

   logic             valid_ff;
   logic [PAD_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;

   always_comb begin
      bin_in = in_bin;
      bcd_in = in_bcd;
      for (int s = 0; s < b2da_pkg::STEPS_PER_STAGE; s++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (bcd_in[d*4 +: 4] >= 4'd5) begin
               bcd_in[d*4 +: 4] = bcd_in[d*4 +: 4] + 4'd3;
            end
         end
         bcd_in = {bcd_in[BCD_W-2:0], bin_in[PAD_W-1]};
         bin_in = {bin_in[PAD_W-2:0], 1'b0};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         bin_ff <= bin_in;
         bcd_ff <= bcd_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_bin   = bin_ff;
   assign out_bcd   = bcd_ff;

endmodule

// ===== rtl/b2da_emitter.sv =====
// ----------------------------------------------------------------------------
// b2da_emitter
// Skips leading zero digits and sends the remaining digits as ASCII
// characters, most significant first, through an output register.
// ----------------------------------------------------------------------------
module b2da_emitter #(
   parameter int BCD_W = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [BCD_W-1:0] in_bcd,
   b2da_rsp_if.source       rsp_ch
);

   localparam int NUM_DIGITS = BCD_W / b2da_pkg::DIGIT_W;
   localparam int IDX_W      = $clog2(NUM_DIGITS);

   logic                        busy_ff;
   logic [BCD_W-1:0]            bcd_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic [IDX_W-1:0]            lead_in;
   logic                        out_valid_ff;
   logic [b2da_pkg::CHAR_W-1:0] out_char_ff;
   logic                        out_last_ff;
   logic                        advance;
   logic [3:0]                  digit;

   always_comb begin
      lead_in = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (in_bcd[i*4 +: 4] != 4'd0) begin
            lead_in = IDX_W'(i);
         end
      end
   end

   assign digit    = bcd_ff[idx_ff*4 +: 4];
   assign advance  = !out_valid_ff || rsp_ch.ready;
   assign in_ready = !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!busy_ff) begin
            if (in_valid) begin
               busy_ff <= 1'b1;
               bcd_ff  <= in_bcd;
               idx_ff  <= lead_in;
            end
            if (advance) begin
               out_valid_ff <= 1'b0;
            end
         end else if (advance) begin
            out_valid_ff <= 1'b1;
            out_char_ff  <= b2da_pkg::ASCII_ZERO + {2'b00, digit};
            out_last_ff  <= (idx_ff == '0);
            if (idx_ff == '0) begin
               busy_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff - 1'b1;
            end
         end
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.char_code  = out_char_ff;
   assign rsp_ch.last_digit = out_last_ff;

   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy_ff) |-> out_valid_ff && out_last_ff)
      else $error("Digit run ended without a last digit.");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_char_ff >= b2da_pkg::ASCII_ZERO &&
                       out_char_ff <= b2da_pkg::ASCII_NINE)
      else $error("Character is not a decimal digit.");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !advance |=> busy_ff && $stable(idx_ff))
      else $error("Digit index moved while the output was stalled.");

endmodule

// ===== rtl/binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned binary number to decimal ASCII digits, most
// significant first, with no leading zeros and a flag on the last digit.
// ----------------------------------------------------------------------------
// A number enters a shift and add-3 pipeline of ceil(VALUE_BITS / 8) stages,
// eight bit steps each, and can be accepted in every cycle while the pipeline
// moves. The digit emitter then takes one number and sends one character per
// cycle while the output is ready, and takes no new number until it has sent
// the last digit of the current one, so this single character output sets the
// sustained rate. A value of zero gives the single character '0'.
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   b2da_req_if.sink   req_ch,
   b2da_rsp_if.source rsp_ch
);

   localparam int NUM_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BCD_W      = NUM_DIGITS * b2da_pkg::DIGIT_W;
   localparam int NUM_STAGES = (VALUE_BITS + b2da_pkg::STEPS_PER_STAGE - 1) /
                               b2da_pkg::STEPS_PER_STAGE;
   localparam int PAD_W      = NUM_STAGES * b2da_pkg::STEPS_PER_STAGE;

   logic [NUM_STAGES:0] stage_valid;
   logic [NUM_STAGES:0] stage_ready;
   logic [PAD_W-1:0]    stage_bin [NUM_STAGES+1];
   logic [BCD_W-1:0]    stage_bcd [NUM_STAGES+1];

   assign stage_valid[0] = req_ch.valid;
   assign req_ch.ready   = stage_ready[0];
   assign stage_bin[0]   = PAD_W'(req_ch.value);
   assign stage_bcd[0]   = '0;

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      b2da_dabble_stage #(
         .PAD_W (PAD_W),
         .BCD_W (BCD_W)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_bin    (stage_bin[g]),
         .in_bcd    (stage_bcd[g]),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_bin   (stage_bin[g+1]),
         .out_bcd   (stage_bcd[g+1])
      );
   end

   b2da_emitter #(
      .BCD_W (BCD_W)
   ) u_emitter (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stage_valid[NUM_STAGES]),
      .in_ready (stage_ready[NUM_STAGES]),
      .in_bcd   (stage_bcd[NUM_STAGES]),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== test/b2da_digit_checker.sv =====
// ----------------------------------------------------------------------------
// b2da_digit_checker
// Watches both channels of the converter, predicts the digit items of every
// accepted number and compares each accepted character item with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module b2da_digit_checker #(
   parameter int VALUE_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [VALUE_BITS-1:0]       req_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [b2da_pkg::CHAR_W-1:0] rsp_char_code,
   input  logic                        rsp_last_digit,
   output int                          mismatch_count,
   output int                          digits_pending,
   output int                          values_taken,
   output int                          digits_taken
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [b2da_pkg::CHAR_W-1:0] char_code;
      logic                        last_digit;
   } digit_type;

   digit_type expected_digits[$];
   int        reported;

   function automatic void queue_digits(input logic [VALUE_BITS-1:0] value);
      logic [63:0] rest;
      logic [3:0]  stack[$];
      digit_type   d;
      rest = 64'(value);
      do begin
         stack.push_back(4'(rest % 64'd10));
         rest = rest / 64'd10;
      end while (rest != 64'd0);
      for (int k = stack.size() - 1; k >= 0; k--) begin
         d.char_code  = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(stack[k]);
         d.last_digit = (k == 0);
         expected_digits.push_back(d);
      end
   endfunction

   initial begin
      reported = 0;
   end

   always @(posedge clock) begin : watch
      digit_type want;
      if (reset) begin
         mismatch_count <= 0;
         digits_pending <= 0;
         values_taken   <= 0;
         digits_taken   <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            digits_taken <= digits_taken + 1;
            if (expected_digits.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (reported < REPORT_LIMIT) begin
                  $display("unexpected item: char_code %0d last_digit %0d",
                           rsp_char_code, rsp_last_digit);
                  reported++;
               end
            end else begin
               want = expected_digits.pop_front();
               if (rsp_char_code !== want.char_code || rsp_last_digit !== want.last_digit) begin
                  mismatch_count <= mismatch_count + 1;
                  if (reported < REPORT_LIMIT) begin
                     $display("mismatch: char_code exp %0d got %0d, last_digit exp %0d got %0d",
                              want.char_code, rsp_char_code, want.last_digit, rsp_last_digit);
                     reported++;
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            values_taken <= values_taken + 1;
            queue_digits(req_value);
         end
         digits_pending <= expected_digits.size();
      end
   end

endmodule

// ===== test/binary_to_decimal_ascii_tb.sv =====
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_tb
// Drives directed corner values and random numbers of every length into the
// converter, with random gaps on both channels, a long output stall and a
// full drain pause, and reports the verdict of the digit checker.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_tb;

   localparam int VALUE_BITS     = 32;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 60;

   localparam logic [31:0] CORNER_VALUES [16] = '{
      32'd0, 32'd4294967295, 32'd4294967294, 32'd2147483648,
      32'd2147483647, 32'hAAAAAAAA, 32'h55555555, 32'd1000000000,
      32'd999999999, 32'd9, 32'd10, 32'd99,
      32'd100, 32'd1, 32'd12345, 32'd4000000000
   };

   logic clock;
   logic reset;
   bit   steady;
   bit   hold_output;
   int   idle_cycles;
   int   mismatch_count;
   int   digits_pending;
   int   values_taken;
   int   digits_taken;

   b2da_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   b2da_rsp_if                            rsp_ch ();

   binary_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   b2da_digit_checker #(.VALUE_BITS(VALUE_BITS)) digit_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_value      (req_ch.value),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_char_code  (rsp_ch.char_code),
      .rsp_last_digit (rsp_ch.last_digit),
      .mismatch_count (mismatch_count),
      .digits_pending (digits_pending),
      .values_taken   (values_taken),
      .digits_taken   (digits_taken)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] random_value();
      int          pick;
      int          k;
      logic [63:0] span;
      pick = $urandom_range(0, 9);
      k    = $urandom_range(1, 9);
      span = 64'd1;
      repeat (k) span = span * 64'd10;
      if (pick < 4) return $urandom;
      else if (pick < 8) return 32'(64'($urandom) % span);
      else if (pick == 8) return 32'(span - 64'($urandom_range(0, 1)));
      else if ($urandom_range(0, 1) == 0) return 32'($urandom_range(0, 20));
      else return 32'hFFFFFFFF - 32'($urandom_range(0, 20));
   endfunction

   // Valid stays high from one item to the next when there is no gap.
   task automatic send_value(input logic [31:0] value, input int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (digits_pending != 0) @(posedge clock);
   endtask

   initial begin : rsp_ready_drive
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_output) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_output = 1'b0;
         end else if (steady) begin
            rsp_ch.ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d cycles without an item", idle_cycles);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int errors;
      steady       = 1'b0;
      hold_output  = 1'b0;
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (CORNER_VALUES[i]) send_value(CORNER_VALUES[i], pick_gap());
      repeat (130) send_value(random_value(), pick_gap());

      // The output stalls while numbers keep coming, so the input backs up.
      hold_output = 1'b1;
      repeat (40) send_value(random_value(), 0);
      wait_for_drain();

      steady = 1'b1;
      repeat (100) send_value(random_value(), 0);
      steady = 1'b0;
      repeat (124) send_value(random_value(), pick_gap());

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      errors = mismatch_count + digits_pending;
      $display("Converted %0d numbers into %0d digit items, corner values included,",
               values_taken, digits_taken);
      $display("with random gaps, a %0d-cycle output stall and a full drain pause.", LONG_HOLD);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
